// ===== sv/ir_pulse_train_player_core_defines.svh =====
// ---------------------------------------------------------------------------
// IR pulse train player: assertion macros
// Shared concurrent assertion forms used by the controller and the datapath.
// ---------------------------------------------------------------------------
`ifndef IR_PULSE_TRAIN_PLAYER_CORE_DEFINES_SVH
`define IR_PULSE_TRAIN_PLAYER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IRP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/irp_pkg.sv =====
// ---------------------------------------------------------------------------
// IR pulse train player: package
// Field widths, command and status codes, and the control/status bundles
// passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package irp_pkg;

  // Field widths.
  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int TOTAL_W  = 16;
  localparam int STATUS_W = 3;
  localparam int DUR_W    = 16;
  localparam int DUTY_W   = 7;

  // Command codes. Any other code behaves as finish.
  localparam logic [CMD_W-1:0] CMD_BEGIN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_APPEND_REFUSED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FINISH_REFUSED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICK_IDLE      = 3'd4;

  // Sequence marker word and duty limits.
  localparam logic [DUR_W-1:0]  MARKER_WORD = 16'hFFFF;
  localparam logic [DUTY_W-1:0] DUTY_RESET  = 7'd30;
  localparam logic [DUTY_W-1:0] DUTY_LIMIT  = 7'd100;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the accepted item
    logic exec;      // decode and apply the item
    logic first;     // first word of a new playback is on the read port
    logic look;      // current word is on the read port, fetch lookahead
    logic pick;      // lookahead word is on the read port, choose and emit
    logic load_out;  // move the result into the output register
  } irp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_play;  // finish accepted with a non-empty sequence
    logic tick_word;   // tick while playing with a word left to give
  } irp_stat_t;

endpackage

// ===== sv/irp_if.sv =====
// ---------------------------------------------------------------------------
// IR pulse train player: channel interfaces
// Valid/ready channels for input items, results and the duty register write.
// ---------------------------------------------------------------------------

// Input item channel.
interface irp_item_if import irp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [BYTE_W-1:0]    data_byte;
  logic [TOTAL_W-1:0]   total_bytes;

  modport source (output valid, command, data_byte, total_bytes, input ready);
  modport sink   (input valid, command, data_byte, total_bytes, output ready);
endinterface

// Result channel.
interface irp_result_if import irp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 new_period;
  logic [DUR_W-1:0]     duration;
  logic [DUTY_W-1:0]    duty;
  logic                 finished;

  modport source (output valid, status, new_period, duration, duty, finished,
                  input ready);
  modport sink   (input valid, status, new_period, duration, duty, finished,
                  output ready);
endinterface

// Carrier duty register write channel.
interface irp_cfg_if import irp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DUTY_W-1:0]    carrier_duty;

  modport source (output valid, carrier_duty, input ready);
  modport sink   (input valid, carrier_duty, output ready);
endinterface

// ===== sv/ir_pulse_train_player_core.sv =====
// ---------------------------------------------------------------------------
// IR pulse train player core
// Loads a raw mark/space timing sequence byte by byte and plays it back one
// duration per period tick, with carrier duty on marks and none on spaces.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                    Handshake
//   item     in         command, data_byte, total_bytes            valid/ready
//   result   out        status, new_period, duration, duty,        valid/ready
//                       finished
//   cfg      in         carrier_duty                               valid/ready
//
// Begin, append, timeout, refused or idle ticks pass through decode and
// hand-over. A finish that starts playback adds a first-word step, and a
// playing tick a lookahead step and a word choice: it reads the current word
// and lookahead via the byte-pair store's single read port, one word per cycle.
// Reset is synchronous; the store contents are not cleared and need no pass.
// A finished result waits in the output register while the next item is
// taken; the block only holds in its hand-over step if that result is still
// untaken. Duty writes are always accepted.
// ---------------------------------------------------------------------------
module ir_pulse_train_player_core import irp_pkg::*; #(
  parameter int MAX_BYTES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  irp_item_if.sink     item,
  irp_result_if.source result,
  irp_cfg_if.sink      cfg
);

  irp_ctrl_t ctl;
  irp_stat_t stat;

  // Duty writes complete on any cycle.
  assign cfg.ready = 1'b1;

  // Sequencing of each transfer.
  irp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .stat       (stat),
    .ctl        (ctl)
  );

  // Store, state and result registers.
  irp_datapath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .command     (item.command),
    .data_byte   (item.data_byte),
    .total_bytes (item.total_bytes),
    .cfg_we      (cfg.valid),
    .cfg_duty    (cfg.carrier_duty),
    .status      (result.status),
    .new_period  (result.new_period),
    .duration    (result.duration),
    .duty        (result.duty),
    .finished    (result.finished)
  );

endmodule

// ===== sv/irp_ctrl.sv =====
// ---------------------------------------------------------------------------
// IR pulse train player: controller
// Sequences each item through decode, store reads and result hand-over.
// ---------------------------------------------------------------------------
`include "ir_pulse_train_player_core_defines.svh"

module irp_ctrl import irp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  irp_stat_t stat,
  output irp_ctrl_t ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;
  logic       out_free;

  assign item_ready = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (stat.start_play) begin
          state_next = S_FIRST;
        end else if (stat.tick_word) begin
          state_next = S_LOOK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_FIRST: begin
        ctl.first  = 1'b1;
        state_next = S_OUT;
      end
      S_LOOK: begin
        ctl.look   = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        ctl.pick   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `IRP_ASSERT_NEXT(a_accept_starts_exec, clk, rst, item_valid && item_ready, state == S_EXEC, "accepted item did not move to execution")
  `IRP_ASSERT_NOW(a_no_result_overwrite, clk, rst, ctl.load_out, out_free, "result loaded over an untaken result")
  `IRP_ASSERT_NOW(a_pick_follows_look, clk, rst, state == S_PICK, $past(state) == S_LOOK, "word choice without a lookahead read")

endmodule

// ===== sv/irp_datapath.sv =====
// ---------------------------------------------------------------------------
// IR pulse train player: datapath
// Byte store, load and playback state, word selection and result registers.
// ---------------------------------------------------------------------------
`include "ir_pulse_train_player_core_defines.svh"

module irp_datapath import irp_pkg::*; #(
  parameter int MAX_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  irp_ctrl_t           ctl,
  output irp_stat_t           stat,
  input  logic [CMD_W-1:0]    command,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic [TOTAL_W-1:0]  total_bytes,
  input  logic                cfg_we,
  input  logic [DUTY_W-1:0]   cfg_duty,
  output logic [STATUS_W-1:0] status,
  output logic                new_period,
  output logic [DUR_W-1:0]    duration,
  output logic [DUTY_W-1:0]   duty,
  output logic                finished
);

  // Byte count holds up to MAX_BYTES, positions up to MAX_BYTES/2 words.
  localparam int CW  = $clog2(MAX_BYTES + 1);
  localparam int PW  = $clog2(MAX_BYTES / 2 + 1);
  localparam int WD  = (MAX_BYTES + 1) / 2;
  localparam int WAW = $clog2(WD);
  localparam int XW  = TOTAL_W + 1;

  // Captured item.
  logic [CMD_W-1:0]   cmd_q;
  logic [BYTE_W-1:0]  data_q;
  logic [TOTAL_W-1:0] total_q;

  // Load and playback state.
  logic [CW-1:0]      byte_count;
  logic [PW-1:0]      play_length;
  logic [PW-1:0]      play_position;
  logic               playing;
  logic               store_valid;
  logic [DUTY_W-1:0]  carrier_duty;

  // Store: high bytes in one bank, low bytes in the other, one word per read.
  logic [BYTE_W-1:0]  bank_hi [WD];
  logic [BYTE_W-1:0]  bank_lo [WD];
  logic [BYTE_W-1:0]  hi_q, lo_q;
  logic [DUR_W-1:0]   mem_q;
  logic               wr_en, wr_odd, rd_en;
  logic [WAW-1:0]     wr_addr, rd_addr;
  logic [DUR_W-1:0]   cur_word;

  // Pending result and output register.
  logic [STATUS_W-1:0] res_status;
  logic                res_np;
  logic [DUR_W-1:0]    res_dur;
  logic [DUTY_W-1:0]   res_duty;
  logic                res_fin;

  // Decode terms.
  logic               abort, sv_eff, is_finish;
  logic               len_ok, append_ok, finish_ok, have_word;
  logic [XW-1:0]      total_x, count_x, max_x;
  logic [PW-1:0]      fin_len;
  logic               look_ok, skip, play_done;
  logic [PW-1:0]      pos_inc, sel_pos, new_pos;
  logic [STATUS_W-1:0] exec_status;
  logic               exec_fin;

  assign mem_q = {hi_q, lo_q};

  // Decode of the captured item against the current state.
  always_comb begin
    abort     = playing && (cmd_q != CMD_TICK) && (cmd_q != CMD_TIMEOUT);
    sv_eff    = store_valid && !playing;
    is_finish = !(cmd_q inside {CMD_BEGIN, CMD_APPEND, CMD_TICK, CMD_TIMEOUT});
    total_x   = XW'(total_q);
    count_x   = XW'(byte_count);
    max_x     = XW'(MAX_BYTES);
    len_ok    = (total_q != '0) && (total_x < max_x);
    append_ok = sv_eff && (byte_count != '0) && (count_x < total_x) && (count_x < max_x);
    finish_ok = sv_eff && (total_x == count_x);
    fin_len   = PW'(byte_count >> 1);
    have_word = play_length > play_position;

    stat.start_play = is_finish && finish_ok && (fin_len != '0);
    stat.tick_word  = (cmd_q == CMD_TICK) && playing && have_word;

    exec_status = ST_OK;
    exec_fin    = abort;
    case (cmd_q)
      CMD_BEGIN: begin
        if (!len_ok) exec_status = ST_BAD_LENGTH;
      end
      CMD_APPEND: begin
        if (!append_ok) exec_status = ST_APPEND_REFUSED;
      end
      CMD_TICK: begin
        if (!playing) exec_status = ST_TICK_IDLE;
        else if (!have_word) exec_fin = 1'b1;
      end
      CMD_TIMEOUT: begin
        exec_fin = playing;
      end
      default: begin
        // Finish, and the unused codes that act as finish.
        if (!finish_ok) exec_status = ST_FINISH_REFUSED;
        else if (fin_len == '0) exec_fin = 1'b1;
      end
    endcase
  end

  // Marker skip: a marker word followed by a non-marker word is passed over.
  always_comb begin
    pos_inc   = play_position + PW'(1);
    look_ok   = pos_inc < play_length;
    skip      = (cur_word == MARKER_WORD) && look_ok && (mem_q != MARKER_WORD);
    sel_pos   = skip ? pos_inc : play_position;
    new_pos   = sel_pos + PW'(1);
    play_done = play_length <= new_pos;
  end

  // Store port control.
  always_comb begin
    wr_en   = ctl.exec && (((cmd_q == CMD_BEGIN) && len_ok) ||
                           ((cmd_q == CMD_APPEND) && append_ok));
    wr_addr = (cmd_q == CMD_BEGIN) ? '0 : WAW'(byte_count >> 1);
    wr_odd  = (cmd_q == CMD_BEGIN) ? 1'b0 : byte_count[0];
    rd_en   = (ctl.exec && (stat.start_play || stat.tick_word)) || ctl.look;
    if (ctl.look) begin
      rd_addr = pos_inc[WAW-1:0];
    end else if (stat.start_play) begin
      rd_addr = '0;
    end else begin
      rd_addr = play_position[WAW-1:0];
    end
  end

  // Byte store banks.
  always_ff @(posedge clk) begin
    if (wr_en && !wr_odd) bank_hi[wr_addr] <= data_q;
    if (rd_en) hi_q <= bank_hi[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_odd) bank_lo[wr_addr] <= data_q;
    if (rd_en) lo_q <= bank_lo[rd_addr];
  end

  // Load and playback state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      play_length   <= '0;
      play_position <= '0;
      playing       <= 1'b0;
      store_valid   <= 1'b0;
      carrier_duty  <= DUTY_RESET;
    end else begin
      if (cfg_we) begin
        carrier_duty <= (cfg_duty > DUTY_LIMIT) ? DUTY_LIMIT : cfg_duty;
      end
      if (ctl.exec) begin
        if (abort) begin
          playing       <= 1'b0;
          play_length   <= '0;
          play_position <= '0;
          store_valid   <= 1'b0;
        end
        case (cmd_q)
          CMD_BEGIN: begin
            if (len_ok) begin
              byte_count  <= CW'(1);
              store_valid <= 1'b1;
            end else begin
              byte_count  <= '0;
              store_valid <= 1'b0;
            end
          end
          CMD_APPEND: begin
            if (append_ok) begin
              byte_count <= byte_count + CW'(1);
            end else begin
              byte_count  <= '0;
              store_valid <= 1'b0;
            end
          end
          CMD_TICK: begin
            if (playing && !have_word) begin
              playing       <= 1'b0;
              play_length   <= '0;
              play_position <= '0;
              store_valid   <= 1'b0;
            end
          end
          CMD_TIMEOUT: begin
            playing       <= 1'b0;
            play_length   <= '0;
            play_position <= '0;
            store_valid   <= 1'b0;
          end
          default: begin
            if (!finish_ok) begin
              byte_count  <= '0;
              store_valid <= 1'b0;
            end else if (fin_len == '0) begin
              playing       <= 1'b0;
              play_length   <= '0;
              play_position <= '0;
              store_valid   <= 1'b0;
            end else begin
              playing       <= 1'b1;
              play_length   <= fin_len;
              play_position <= '0;
            end
          end
        endcase
      end
      if (ctl.first) begin
        play_position <= PW'(1);
      end
      if (ctl.pick) begin
        if (play_done) begin
          playing       <= 1'b0;
          play_length   <= '0;
          play_position <= '0;
          store_valid   <= 1'b0;
        end else begin
          play_position <= new_pos;
        end
      end
    end
  end

  // Item capture, current word and result registers.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q   <= command;
      data_q  <= data_byte;
      total_q <= total_bytes;
    end
    if (ctl.look) begin
      cur_word <= mem_q;
    end
    if (ctl.exec) begin
      res_status <= exec_status;
      res_np     <= 1'b0;
      res_dur    <= '0;
      res_duty   <= '0;
      res_fin    <= exec_fin;
    end
    if (ctl.first) begin
      res_status <= ST_OK;
      res_np     <= 1'b1;
      res_dur    <= mem_q;
      res_duty   <= carrier_duty;
      res_fin    <= 1'b0;
    end
    if (ctl.pick) begin
      res_status <= ST_OK;
      res_np     <= 1'b1;
      res_dur    <= skip ? mem_q : cur_word;
      res_duty   <= sel_pos[0] ? '0 : carrier_duty;
      res_fin    <= play_done;
    end
    if (ctl.load_out) begin
      status     <= res_status;
      new_period <= res_np;
      duration   <= res_dur;
      duty       <= res_duty;
      finished   <= res_fin;
    end
  end

  `IRP_ASSERT_NOW(a_playing_has_sequence, clk, rst, playing, (play_length != '0) && store_valid, "playback running without a loaded sequence")
  `IRP_ASSERT_NOW(a_position_in_range, clk, rst, 1'b1, play_position <= play_length, "play position beyond sequence length")

endmodule
